/* rtl/tfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

  localparam int SENSE_W = 10;
  localparam int SPEED_W = 10;
  localparam int CALC_W  = 12;
  localparam int TRIM_W  = 7;
  localparam int PWM_W   = 8;
  localparam int TIME_W  = 32;
  localparam int MAG_W   = 11;
  localparam int COEF_W  = 14;
  localparam int PROD_W  = MAG_W + COEF_W;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = PROD_W - FRAC_W;

  localparam logic [COEF_W-1:0] STEP_SMALL_Q16 = 14'd3932;
  localparam logic [COEF_W-1:0] STEP_LARGE_Q16 = 14'd12452;
  localparam logic signed [CALC_W-1:0] STEP_BIAS = 12'sd180;
  localparam logic [TIME_W-1:0] END_DELAY_MS = 32'd2500;
  localparam logic [7:0] FAST_DEFAULT = 8'd160;
  localparam logic [7:0] FAST_MAX     = 8'd200;
  localparam logic [7:0] SLOW_DEFAULT = 8'd115;
  localparam logic [7:0] SLOW_MAX     = 8'd155;
  localparam logic [SENSE_W-1:0] THRESH_RESET = 10'd400;
  localparam logic [PWM_W-1:0] PWM_SAT = 8'd255;

  typedef enum logic [2:0] {
    SENS_NONE      = 3'd0,
    SENS_FAR_LEFT  = 3'd1,
    SENS_LEFT      = 3'd2,
    SENS_CENTRE    = 3'd3,
    SENS_RIGHT     = 3'd4,
    SENS_FAR_RIGHT = 3'd5
  } sensor_t;

  typedef enum logic [2:0] {
    ACT_HOLD      = 3'd0,
    ACT_LOAD      = 3'd1,
    ACT_ADD_SMALL = 3'd2,
    ACT_ADD_LARGE = 3'd3,
    ACT_SUB_LARGE = 3'd4
  } wheel_act_t;

  typedef enum logic [2:0] {
    REG_THR_FAR_LEFT  = 3'd0,
    REG_THR_LEFT      = 3'd1,
    REG_THR_CENTRE    = 3'd2,
    REG_THR_RIGHT     = 3'd3,
    REG_THR_FAR_RIGHT = 3'd4,
    REG_LEFT_TRIM     = 3'd5,
    REG_RIGHT_TRIM    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CALC_W-1:0] left;
    logic signed [CALC_W-1:0] right;
    logic                     end_flag;
    logic                     slow;
  } drive_t;

endpackage

`default_nettype wire

/* rtl/tfs_wheel_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfs_wheel_lane (
  input  wire logic signed [tfs_pkg::SPEED_W-1:0] speed,
  input  wire tfs_pkg::wheel_act_t                act,
  input  wire logic [7:0]                         dflt,
  input  wire logic signed [tfs_pkg::TRIM_W-1:0]  trim,
  input  wire logic [7:0]                         mx,
  output logic signed [tfs_pkg::SPEED_W-1:0]      speed_nxt
);

  logic signed [tfs_pkg::CALC_W-1:0] base;
  logic signed [tfs_pkg::CALC_W-1:0] x;
  logic signed [tfs_pkg::CALC_W-1:0] neg_x;
  logic [tfs_pkg::MAG_W-1:0]         mag;
  logic [tfs_pkg::COEF_W-1:0]        coef;
  logic [tfs_pkg::PROD_W-1:0]        prod;
  logic [tfs_pkg::STEP_W-1:0]        frac;
  logic signed [tfs_pkg::CALC_W-1:0] step;
  logic signed [tfs_pkg::CALC_W-1:0] sum;
  logic signed [tfs_pkg::CALC_W-1:0] mx_s;
  logic signed [tfs_pkg::CALC_W-1:0] clamped;

  always_comb begin
    base  = tfs_pkg::CALC_W'(speed);
    x     = base + tfs_pkg::STEP_BIAS;
    neg_x = -x;
    mag   = x[tfs_pkg::CALC_W-1] ? neg_x[tfs_pkg::MAG_W-1:0] : x[tfs_pkg::MAG_W-1:0];
    coef  = (act == tfs_pkg::ACT_ADD_SMALL) ? tfs_pkg::STEP_SMALL_Q16
                                            : tfs_pkg::STEP_LARGE_Q16;
    prod  = tfs_pkg::PROD_W'(mag) * tfs_pkg::PROD_W'(coef);
    frac  = prod[tfs_pkg::PROD_W-1:tfs_pkg::FRAC_W];
    // truncate toward zero: scale the magnitude, then restore the sign
    if (x[tfs_pkg::CALC_W-1]) begin
      step = -$signed({{(tfs_pkg::CALC_W-tfs_pkg::STEP_W){1'b0}}, frac});
    end else begin
      step = $signed({{(tfs_pkg::CALC_W-tfs_pkg::STEP_W){1'b0}}, frac});
    end

    case (act)
      tfs_pkg::ACT_HOLD:      sum = base;
      tfs_pkg::ACT_LOAD:      sum = $signed({4'b0, dflt}) + tfs_pkg::CALC_W'(trim);
      tfs_pkg::ACT_ADD_SMALL: sum = base + step;
      tfs_pkg::ACT_ADD_LARGE: sum = base + step;
      tfs_pkg::ACT_SUB_LARGE: sum = base - step;
      default:                sum = base;
    endcase

    mx_s = $signed({4'b0, mx});
    if (sum > mx_s) begin
      clamped = mx_s;
    end else if (sum < -mx_s) begin
      clamped = -mx_s;
    end else begin
      clamped = sum;
    end
    speed_nxt = clamped[tfs_pkg::SPEED_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/tfs_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfs_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tfs_pkg::drive_t   drv,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [39:0]            out_tdata
);

  logic signed [tfs_pkg::CALC_W-1:0] l_neg;
  logic signed [tfs_pkg::CALC_W-1:0] r_neg;
  logic [tfs_pkg::MAG_W-1:0]         l_mag;
  logic [tfs_pkg::MAG_W-1:0]         r_mag;
  logic [tfs_pkg::PWM_W-1:0]         l_pwm;
  logic [tfs_pkg::PWM_W-1:0]         r_pwm;
  logic [tfs_pkg::PWM_W-1:0]         lfwd, lrev, rfwd, rrev;
  logic                              valid_r;
  logic [39:0]                       data_r;
  logic [39:0]                       data_nxt;

  always_comb begin
    l_neg = -drv.left;
    r_neg = -drv.right;
    l_mag = drv.left[tfs_pkg::CALC_W-1]  ? l_neg[tfs_pkg::MAG_W-1:0]
                                         : drv.left[tfs_pkg::MAG_W-1:0];
    r_mag = drv.right[tfs_pkg::CALC_W-1] ? r_neg[tfs_pkg::MAG_W-1:0]
                                         : drv.right[tfs_pkg::MAG_W-1:0];
    l_pwm = (l_mag > tfs_pkg::MAG_W'(tfs_pkg::PWM_SAT)) ? tfs_pkg::PWM_SAT
                                                        : l_mag[tfs_pkg::PWM_W-1:0];
    r_pwm = (r_mag > tfs_pkg::MAG_W'(tfs_pkg::PWM_SAT)) ? tfs_pkg::PWM_SAT
                                                        : r_mag[tfs_pkg::PWM_W-1:0];
    lfwd  = drv.left[tfs_pkg::CALC_W-1]  ? '0 : l_pwm;
    lrev  = drv.left[tfs_pkg::CALC_W-1]  ? l_pwm : '0;
    rfwd  = drv.right[tfs_pkg::CALC_W-1] ? '0 : r_pwm;
    rrev  = drv.right[tfs_pkg::CALC_W-1] ? r_pwm : '0;
    data_nxt = {6'b0, drv.slow, drv.end_flag, rrev, rfwd, lrev, lfwd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

/* rtl/tape_follow_steering_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Steering core for a five-sensor tape follower.
// Input stream: one word per sensor scan (five reflectance samples plus a
// millisecond time stamp). Output stream: one word per input word with the
// four H-bridge PWM magnitudes and the end and slow-mode flags.
// Thresholds and forward trims are set on the cfg_ write port; the user must
// set them only while idle, as the block does not enforce it. The result
// word reaches the output register in the cycle after the input word is
// taken. One word per cycle when the output does not stall; the wheel
// speeds, last-seen sensor and mode flags loop through threshold compares,
// two wheel lanes (constant multiply, add, clamp) and the state registers.
// Reset clears both speeds, the last-seen sensor, slow mode, its time mark
// and the done flag, and sets every threshold to 400 and both trims to zero.
// When the receiver stalls, the output register holds its word and
// in_tready drops until the word is taken; a waiting word and a new input
// word may be exchanged in the same cycle.
// Once the end marker is seen, every later word carries zero drive.

module tape_follow_steering_core #(
  parameter int LEFT_REV_TRIM  = 0,
  parameter int RIGHT_REV_TRIM = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sense_far_left, sense_left, sense_centre, sense_right, sense_far_right,
  // now_ms, zero fill
  input  wire logic [87:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // left_fwd_pwm, left_rev_pwm, right_fwd_pwm, right_rev_pwm, end_reached,
  // slow_active, zero fill
  output logic [39:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [9:0]  cfg_wdata
);

  localparam int NUM_SENS = 5;

  logic [tfs_pkg::SENSE_W-1:0]        thr_r [NUM_SENS];
  logic signed [tfs_pkg::TRIM_W-1:0]  trim_l_r;
  logic signed [tfs_pkg::TRIM_W-1:0]  trim_r_r;

  logic signed [tfs_pkg::SPEED_W-1:0] left_speed_r,  left_speed_nxt;
  logic signed [tfs_pkg::SPEED_W-1:0] right_speed_r, right_speed_nxt;
  tfs_pkg::sensor_t                   last_r, last_nxt;
  logic                               slow_r, slow_nxt;
  logic [tfs_pkg::TIME_W-1:0]         mark_r, mark_nxt;
  logic                               finished_r, finished_nxt;

  logic [tfs_pkg::SENSE_W-1:0]        sense [NUM_SENS];
  logic [NUM_SENS-1:0]                seen;
  logic [tfs_pkg::TIME_W-1:0]         now_ms;
  logic [tfs_pkg::TIME_W-1:0]         elapsed;
  logic                               end_hit;
  logic                               rev;
  logic                               speed_we;
  logic [7:0]                         dflt, mx;
  tfs_pkg::wheel_act_t                act_l, act_r;
  logic signed [tfs_pkg::SPEED_W-1:0] lane_l, lane_r;
  logic signed [tfs_pkg::CALC_W-1:0]  rev_l, rev_r;
  tfs_pkg::drive_t                    drv;
  logic                               in_acc;

  assign in_tready = !out_tvalid || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign now_ms    = in_tdata[81:50];

  for (genvar i = 0; i < NUM_SENS; i++) begin : g_sense
    assign sense[i] = in_tdata[i*tfs_pkg::SENSE_W +: tfs_pkg::SENSE_W];
    assign seen[i]  = sense[i] > thr_r[i];
  end

  always_comb begin
    slow_nxt     = slow_r;
    mark_nxt     = mark_r;
    finished_nxt = finished_r;
    last_nxt     = last_r;
    act_l        = tfs_pkg::ACT_HOLD;
    act_r        = tfs_pkg::ACT_HOLD;
    rev          = 1'b0;

    if (!finished_r && seen[1] && seen[2] && seen[3] && !slow_r) begin
      slow_nxt = 1'b1;
      mark_nxt = now_ms;
    end
    elapsed = now_ms - mark_nxt;
    end_hit = !finished_r && seen[0] && seen[4] && (elapsed > tfs_pkg::END_DELAY_MS);
    if (end_hit) begin
      finished_nxt = 1'b1;
    end

    dflt = slow_nxt ? tfs_pkg::SLOW_DEFAULT : tfs_pkg::FAST_DEFAULT;
    mx   = slow_nxt ? tfs_pkg::SLOW_MAX : tfs_pkg::FAST_MAX;

    if (seen[2]) begin
      last_nxt = tfs_pkg::SENS_CENTRE;
      act_l    = tfs_pkg::ACT_LOAD;
      act_r    = tfs_pkg::ACT_LOAD;
    end else if (seen[1]) begin
      if (last_r == tfs_pkg::SENS_FAR_LEFT) begin
        act_l = tfs_pkg::ACT_LOAD;
        act_r = tfs_pkg::ACT_LOAD;
      end else begin
        act_r = tfs_pkg::ACT_ADD_SMALL;
      end
      last_nxt = tfs_pkg::SENS_LEFT;
    end else if (seen[3]) begin
      if (last_r == tfs_pkg::SENS_FAR_RIGHT) begin
        act_l = tfs_pkg::ACT_LOAD;
        act_r = tfs_pkg::ACT_LOAD;
      end else begin
        act_l = tfs_pkg::ACT_ADD_SMALL;
      end
      last_nxt = tfs_pkg::SENS_RIGHT;
    end else if (seen[0]) begin
      last_nxt = tfs_pkg::SENS_FAR_LEFT;
      act_l    = tfs_pkg::ACT_SUB_LARGE;
      act_r    = tfs_pkg::ACT_ADD_LARGE;
    end else if (seen[4]) begin
      last_nxt = tfs_pkg::SENS_FAR_RIGHT;
      act_l    = tfs_pkg::ACT_ADD_LARGE;
      act_r    = tfs_pkg::ACT_SUB_LARGE;
    end else if (last_r == tfs_pkg::SENS_FAR_LEFT || last_r == tfs_pkg::SENS_FAR_RIGHT) begin
      rev = 1'b1;
    end

    if (finished_r || end_hit) begin
      last_nxt = last_r;
    end
    speed_we = !finished_r && !end_hit && !rev;

    rev_l = -($signed({4'b0, dflt}) + tfs_pkg::CALC_W'(LEFT_REV_TRIM));
    rev_r = -($signed({4'b0, dflt}) + tfs_pkg::CALC_W'(RIGHT_REV_TRIM));

    left_speed_nxt  = speed_we ? lane_l : left_speed_r;
    right_speed_nxt = speed_we ? lane_r : right_speed_r;

    if (finished_r) begin
      drv = '{left: '0, right: '0, end_flag: 1'b1, slow: slow_r};
    end else if (end_hit) begin
      drv = '{left: '0, right: '0, end_flag: 1'b1, slow: slow_nxt};
    end else if (rev) begin
      drv = '{left: rev_l, right: rev_r, end_flag: 1'b0, slow: slow_nxt};
    end else begin
      drv = '{left: tfs_pkg::CALC_W'(lane_l), right: tfs_pkg::CALC_W'(lane_r),
              end_flag: 1'b0, slow: slow_nxt};
    end
  end

  tfs_wheel_lane u_lane_l (
    .speed     (left_speed_r),
    .act       (act_l),
    .dflt      (dflt),
    .trim      (trim_l_r),
    .mx        (mx),
    .speed_nxt (lane_l)
  );

  tfs_wheel_lane u_lane_r (
    .speed     (right_speed_r),
    .act       (act_r),
    .dflt      (dflt),
    .trim      (trim_r_r),
    .mx        (mx),
    .speed_nxt (lane_r)
  );

  tfs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .drv        (drv),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENS; i++) begin
        thr_r[i] <= tfs_pkg::THRESH_RESET;
      end
      trim_l_r <= '0;
      trim_r_r <= '0;
    end else if (cfg_wr_en) begin
      case (tfs_pkg::cfg_reg_t'(cfg_addr))
        tfs_pkg::REG_THR_FAR_LEFT:  thr_r[0] <= cfg_wdata;
        tfs_pkg::REG_THR_LEFT:      thr_r[1] <= cfg_wdata;
        tfs_pkg::REG_THR_CENTRE:    thr_r[2] <= cfg_wdata;
        tfs_pkg::REG_THR_RIGHT:     thr_r[3] <= cfg_wdata;
        tfs_pkg::REG_THR_FAR_RIGHT: thr_r[4] <= cfg_wdata;
        tfs_pkg::REG_LEFT_TRIM:     trim_l_r <= cfg_wdata[tfs_pkg::TRIM_W-1:0];
        tfs_pkg::REG_RIGHT_TRIM:    trim_r_r <= cfg_wdata[tfs_pkg::TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_speed_r  <= '0;
      right_speed_r <= '0;
      last_r        <= tfs_pkg::SENS_NONE;
      slow_r        <= 1'b0;
      mark_r        <= '0;
      finished_r    <= 1'b0;
    end else if (in_acc) begin
      left_speed_r  <= left_speed_nxt;
      right_speed_r <= right_speed_nxt;
      last_r        <= last_nxt;
      slow_r        <= slow_nxt;
      mark_r        <= mark_nxt;
      finished_r    <= finished_nxt;
    end
  end

  a_done_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && finished_r) |=> (out_tdata[31:0] == 32'd0 && out_tdata[32]))
    else $error("drive not zero after end marker");

  a_one_side_per_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[7:0] == 8'd0 || out_tdata[15:8] == 8'd0) &&
                    (out_tdata[23:16] == 8'd0 || out_tdata[31:24] == 8'd0)))
    else $error("both bridge sides driven");

  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (left_speed_r <= 10'sd200 && left_speed_r >= -10'sd200 &&
     right_speed_r <= 10'sd200 && right_speed_r >= -10'sd200))
    else $error("stored speed beyond limit");

  a_slow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    slow_r |=> slow_r)
    else $error("slow mode dropped");

endmodule

`default_nettype wire
